@@ hw/rtl/lookahead_peak_limiter_core_defines.svh @@
// Assertion macros shared by the lookahead peak limiter RTL.
// No dependencies; included by modules that carry checks.
`ifndef LOOKAHEAD_PEAK_LIMITER_CORE_DEFINES_SVH
`define LOOKAHEAD_PEAK_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LPL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define LPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/lpl_pkg.sv @@
// Shared types, constants and codes for the lookahead peak limiter.
// No dependencies.
package lpl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 17;
  localparam int ENV_BITS    = 25;
  localparam int COEF_BITS   = 16;
  localparam int WIN_BITS    = 9;
  localparam int PTR_BITS    = 8;
  localparam int CH_BITS     = 2;
  localparam int MAX_WINDOW  = 256;
  localparam int CELL_SLOTS  = 8;
  localparam int NUM_CELLS   = MAX_WINDOW / CELL_SLOTS;
  localparam int QUO_BITS    = 16;
  localparam int CNT_BITS    = 4;

  localparam logic [GAIN_BITS-1:0] UNITY16 = 17'd65536;
  localparam logic [ENV_BITS-1:0]  UNITY24 = 25'd16777216;

  localparam logic [GAIN_BITS-1:0] CEILING_RST = 17'd65536;
  localparam logic [COEF_BITS-1:0] RELEASE_RST = 16'd65509;
  localparam logic [WIN_BITS-1:0]  WINDOW_RST  = 9'd240;
  localparam logic [CH_BITS-1:0]   CHANNEL_RST = 2'd2;

  typedef enum logic [1:0] {
    REG_CEILING  = 2'd0,
    REG_RELEASE  = 2'd1,
    REG_WINDOW   = 2'd2,
    REG_CHANNELS = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SHIFT,
    S_LAUNCH,
    S_SCAN,
    S_ENV1,
    S_ENV2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_ch1;
    logic signed [SAMPLE_BITS-1:0] sample_ch0;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_ch1;
    logic signed [SAMPLE_BITS-1:0] out_ch0;
    logic [GAIN_BITS-1:0]          gain_applied;
  } result_t;

  // Minimum wave that runs down the cell chain
  typedef struct packed {
    logic                 valid;
    logic [GAIN_BITS-1:0] min_gain;
  } wave_t;

endpackage

@@ hw/rtl/lpl_cell.sv @@
// One cell of the gain history chain: eight stored gains and one stage
// of the window minimum wave. Depends on lpl_pkg.
module lpl_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift_en,
  input  logic [lpl_pkg::GAIN_BITS-1:0]  gain_in,
  output logic [lpl_pkg::GAIN_BITS-1:0]  gain_out,
  input  logic [lpl_pkg::WIN_BITS-1:0]   win,
  input  lpl_pkg::wave_t                 wave_in,
  output lpl_pkg::wave_t                 wave_out
);
  import lpl_pkg::*;

  logic [GAIN_BITS-1:0] slot [CELL_SLOTS];
  logic [GAIN_BITS-1:0] local_min;

  assign gain_out = slot[CELL_SLOTS-1];

  // Shift the history one frame deeper on each new gain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < CELL_SLOTS; j++) slot[j] <= UNITY16;
    end else if (shift_en) begin
      slot[0] <= gain_in;
      for (int j = 1; j < CELL_SLOTS; j++) slot[j] <= slot[j-1];
    end
  end

  // Minimum over the slots that fall inside the window
  always_comb begin
    local_min = wave_in.min_gain;
    for (int j = 0; j < CELL_SLOTS; j++) begin
      if (WIN_BITS'(CELL_INDEX * CELL_SLOTS + j) < win && slot[j] < local_min) begin
        local_min = slot[j];
      end
    end
  end

  // Advance the wave one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_in.valid;
    end
    wave_out.min_gain <= local_min;
  end

endmodule

@@ hw/rtl/lookahead_peak_limiter_core.sv @@
// Lookahead peak limiter: takes one stereo Q1.23 frame per transfer and
// returns the frame from window-1 transfers earlier scaled by a Q1.16 gain
// envelope (channel 1 passes unscaled when only one channel is active).
// One frame is in work at a time. A frame whose peak exceeds the ceiling
// first passes through the bit-serial divider; every frame then sends a
// minimum wave down the 32-cell gain history chain (one cell per cycle),
// followed by the envelope states S_ENV1 and S_ENV2 and the output state
// S_OUT, which waits while the result register is held by a stalled output.
module lookahead_peak_limiter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  lpl_pkg::frame_t               sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output lpl_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [lpl_pkg::GAIN_BITS-1:0] cfg_data
);
  import lpl_pkg::*;

  `include "lookahead_peak_limiter_core_defines.svh"

  state_t state, state_next;

  logic [GAIN_BITS-1:0]   ceiling;
  logic [COEF_BITS-1:0]   release_coef;
  logic [WIN_BITS-1:0]    window_length;
  logic [CH_BITS-1:0]     active_channels;

  logic [WIN_BITS-1:0]    win_eff;
  logic                   ch1_on;
  logic                   accept;
  logic                   shift_en;
  logic                   launch;
  logic                   load_out;

  logic [SAMPLE_BITS-1:0] abs0, abs1, peak_in;
  logic [39:0]            lim_in;

  logic [PTR_BITS-1:0]    wp;
  logic [PTR_BITS-1:0]    rd_addr;
  logic [2*SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  vld;
  logic [2*SAMPLE_BITS-1:0] rd_word;
  logic                   rd_vld;

  logic [SAMPLE_BITS-1:0] peak;
  logic [QUO_BITS-1:0]    lim_lo;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SAMPLE_BITS:0]   trial;
  logic [QUO_BITS-1:0]    quo;
  logic [CNT_BITS-1:0]    cnt;
  logic [GAIN_BITS-1:0]   req_gain;
  logic                   need_div;

  logic [GAIN_BITS-1:0]   chain [NUM_CELLS+1];
  wave_t                  wave  [NUM_CELLS+1];
  logic [GAIN_BITS-1:0]   attack;

  logic [ENV_BITS-1:0]    env;
  logic [ENV_BITS-1:0]    a24;
  logic [40:0]            prod_a;
  logic [41:0]            prod_b;
  logic [41:0]            env_sum;
  logic [GAIN_BITS-1:0]   gain;

  logic signed [SAMPLE_BITS-1:0] d0, d1;
  logic signed [41:0]     mul0, mul1;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling         <= CEILING_RST;
      release_coef    <= RELEASE_RST;
      window_length   <= WINDOW_RST;
      active_channels <= CHANNEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_CEILING:  ceiling         <= cfg_data;
        REG_RELEASE:  release_coef    <= cfg_data[COEF_BITS-1:0];
        REG_WINDOW:   window_length   <= cfg_data[WIN_BITS-1:0];
        REG_CHANNELS: active_channels <= cfg_data[CH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp window and channel count
  always_comb begin
    if (window_length > WIN_BITS'(MAX_WINDOW)) win_eff = WIN_BITS'(MAX_WINDOW);
    else if (window_length == '0)              win_eff = WIN_BITS'(1);
    else                                       win_eff = window_length;
  end
  assign ch1_on = (active_channels >= CH_BITS'(2));

  // Peak and limit of the incoming frame
  assign abs0    = sample.sample_ch0[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample.sample_ch0)
                                                    : sample.sample_ch0;
  assign abs1    = sample.sample_ch1[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample.sample_ch1)
                                                    : sample.sample_ch1;
  assign peak_in = (ch1_on && abs1 > abs0) ? abs1 : abs0;
  assign lim_in  = {ceiling, 23'b0};

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    shift_en   = 1'b0;
    launch     = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (({peak_in, 16'b0} > lim_in) && (peak_in != '0)) state_next = S_DIV;
          else                                                   state_next = S_SHIFT;
        end
      end
      S_DIV: begin
        if (cnt == '1) state_next = S_SHIFT;
      end
      S_SHIFT: begin
        shift_en   = 1'b1;
        state_next = S_LAUNCH;
      end
      S_LAUNCH: begin
        launch     = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (wave[NUM_CELLS].valid) state_next = S_ENV1;
      end
      S_ENV1: begin
        state_next = S_ENV2;
      end
      S_ENV2: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Frame delay memory
  always_ff @(posedge clk) begin
    if (accept) mem[wp] <= sample;
    rd_word <= mem[rd_addr];
  end

  // Written marks; unwritten entries read as zero samples
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (accept) begin
      vld[wp] <= 1'b1;
    end
    rd_vld <= vld[rd_addr];
  end

  // Write pointer and read address
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (load_out) begin
      wp <= wp + PTR_BITS'(1);
    end
    if (accept) rd_addr <= wp + PTR_BITS'(1) - win_eff[PTR_BITS-1:0];
  end

  // Restoring divider, one quotient bit per cycle
  assign trial = {rem, lim_lo[QUO_BITS-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == S_DIV) begin
      cnt <= cnt + CNT_BITS'(1);
    end else begin
      cnt <= '0;
    end
    if (accept) begin
      peak     <= peak_in;
      rem      <= lim_in[39:16];
      lim_lo   <= lim_in[15:0];
      quo      <= '0;
      need_div <= ({peak_in, 16'b0} > lim_in) && (peak_in != '0);
    end else if (state == S_DIV) begin
      lim_lo <= {lim_lo[QUO_BITS-2:0], 1'b0};
      if (trial >= {1'b0, peak}) begin
        rem <= SAMPLE_BITS'(trial - {1'b0, peak});
        quo <= {quo[QUO_BITS-2:0], 1'b1};
      end else begin
        rem <= trial[SAMPLE_BITS-1:0];
        quo <= {quo[QUO_BITS-2:0], 1'b0};
      end
    end
  end
  assign req_gain = need_div ? {1'b0, quo} : UNITY16;

  // Gain history chain
  assign chain[0]         = req_gain;
  assign wave[0].valid    = launch;
  assign wave[0].min_gain = UNITY16;
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    lpl_cell #(
      .CELL_INDEX (c)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shift_en),
      .gain_in  (chain[c]),
      .gain_out (chain[c+1]),
      .win      (win_eff),
      .wave_in  (wave[c]),
      .wave_out (wave[c+1])
    );
  end

  // Envelope: instant attack, one-pole release
  assign a24     = {attack, 8'b0};
  assign env_sum = {1'b0, prod_a} + prod_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      env <= UNITY24;
    end else if (state == S_ENV2) begin
      if (a24 < env) env <= a24;
      else           env <= env_sum[40:16];
    end
    if (state == S_SCAN && wave[NUM_CELLS].valid) attack <= wave[NUM_CELLS].min_gain;
    if (state == S_ENV1) begin
      prod_a <= 41'(release_coef) * 41'(env);
      prod_b <= 42'(UNITY16 - {1'b0, release_coef}) * 42'(a24);
    end
  end
  assign gain = env[ENV_BITS-1:8];

  // Apply gain to the delayed frame
  assign d0   = rd_vld ? rd_word[SAMPLE_BITS-1:0] : '0;
  assign d1   = rd_vld ? rd_word[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
  assign mul0 = 42'(d0) * $signed(42'({1'b0, gain}));
  assign mul1 = 42'(d1) * $signed(42'({1'b0, gain}));

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (load_out) begin
      result.out_ch0      <= mul0[39:16];
      result.out_ch1      <= ch1_on ? mul1[39:16] : d1;
      result.gain_applied <= gain;
    end
  end

  `LPL_ASSERT_NEXT(a_busy_after_take, clk, rst, accept, sample_stall,
    "input taken while a frame is in work")
  `LPL_ASSERT_NOW(a_env_unity, clk, rst, 1'b1, env <= UNITY24,
    "envelope above unity")
  `LPL_ASSERT_NOW(a_gain_range, clk, rst, result_valid, result.gain_applied <= UNITY16,
    "applied gain above unity")
  `LPL_ASSERT_NOW(a_wave_in_scan, clk, rst, wave[NUM_CELLS].valid, state == S_SCAN,
    "minimum wave finished outside scan")

endmodule
